FILE: src/qfs_pkg.sv
package qfs_pkg;

    // Byte codes that steer the splitter
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Quote mode codes
    localparam logic [1:0] QM_OUTSIDE = 2'd0;
    localparam logic [1:0] QM_SINGLE  = 2'd1;
    localparam logic [1:0] QM_DOUBLE  = 2'd2;

    // Scan state carried from one byte to the next
    typedef struct packed {
        logic [1:0] quote_mode;
        logic       escape_pending;
        logic       field_has_bytes;
    } t_state;

    // One result word
    typedef struct packed {
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       field_done;
        logic       line_done;
    } t_result;

endpackage

FILE: src/qfs_step.sv
module qfs_step
    import qfs_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char_byte,
    input  logic       i_line_last,
    output t_state     o_state,
    output t_result    o_result
);

    t_state     n_state;
    logic       emit;
    logic       done;
    logic [7:0] closer;

    // Classify the byte against the current quote mode
    always_comb begin
        n_state = i_state;
        emit    = 1'b0;
        done    = 1'b0;
        closer  = (i_state.quote_mode == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

        if (i_state.quote_mode != QM_SINGLE && i_state.quote_mode != QM_DOUBLE) begin
            // outside quotes (unused code 3 reads as outside)
            n_state.quote_mode = QM_OUTSIDE;
            if (i_char_byte == CH_SQUOTE || i_char_byte == CH_DQUOTE ||
                i_char_byte == CH_SPACE) begin
                done                    = i_state.field_has_bytes;
                n_state.field_has_bytes = 1'b0;
                if (i_char_byte == CH_SQUOTE) begin
                    n_state.quote_mode = QM_SINGLE;
                end else if (i_char_byte == CH_DQUOTE) begin
                    n_state.quote_mode = QM_DOUBLE;
                end
            end else begin
                emit = 1'b1;
            end
        end else begin
            // inside quotes: escape first, then closer, then backslash
            priority if (i_state.escape_pending) begin
                n_state.escape_pending = 1'b0;
                emit                   = 1'b1;
            end else if (i_char_byte == closer) begin
                n_state.quote_mode      = QM_OUTSIDE;
                done                    = i_state.field_has_bytes;
                n_state.field_has_bytes = 1'b0;
            end else if (i_char_byte == CH_BSLASH) begin
                n_state.escape_pending = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            n_state.field_has_bytes = 1'b1;
        end

        // line end flushes the open field and returns to reset state
        if (i_line_last) begin
            if (n_state.field_has_bytes) begin
                done = 1'b1;
            end
            n_state.field_has_bytes = 1'b0;
            n_state.escape_pending  = 1'b0;
            n_state.quote_mode      = QM_OUTSIDE;
        end
    end

    assign o_state             = n_state;
    assign o_result.field_byte = emit ? i_char_byte : 8'd0;
    assign o_result.byte_valid = emit;
    assign o_result.field_done = done;
    assign o_result.line_done  = i_line_last;

endmodule

FILE: src/quoted_field_splitter.sv
// Quote-aware field splitter: one line byte in, one result word out.
//
// Input channel: i_valid / o_stall carry i_char_byte and i_line_last; a word
// is taken at a rising edge with i_valid high and o_stall low. Mark the final
// byte of each line with i_line_last.
// Output channel: o_valid / i_stall carry o_field_byte, o_byte_valid,
// o_field_done and o_line_done; exactly one result word per input word.
//
// A word lands in the input register, and its result lands in the output register
// once that register is free. Throughput is one word per cycle while the output
// is not stalled; the scan state register is read and rewritten as each word
// moves from input to output register.
//
// Reset (synchronous, active low) empties both registers and returns the
// scan state to outside quotes, no escape, no open field.
// While i_stall is high the result holds; one more word may still be taken
// into the input register, after which o_stall rises until the output moves.
module quoted_field_splitter
    import qfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_line_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_field_byte,
    output logic       o_byte_valid,
    output logic       o_field_done,
    output logic       o_line_done
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    n_out;
    logic       move;
    logic       take;

    // Handshake: output register frees when empty or drained
    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !move;
    assign take    = i_valid && !o_stall;

    qfs_step u_step (
        .i_state     (r_state),
        .i_char_byte (r_in_char),
        .i_line_last (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_char <= i_char_byte;
            r_in_last <= i_line_last;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_field_byte = r_out.field_byte;
    assign o_byte_valid = r_out.byte_valid;
    assign o_field_done = r_out.field_done;
    assign o_line_done  = r_out.line_done;

    // An escape can only be pending inside quotes
    a_escape_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.escape_pending |->
            (r_state.quote_mode == QM_SINGLE || r_state.quote_mode == QM_DOUBLE))
        else $error("escape pending outside quotes");

    // Quote mode never reaches the unused code
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.quote_mode == QM_OUTSIDE || r_state.quote_mode == QM_SINGLE ||
         r_state.quote_mode == QM_DOUBLE))
        else $error("quote mode holds unused code");

    // Line end leaves the scan state clear
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_last) |=> (r_state == '0))
        else $error("scan state not cleared after line end");

    // Input stalls only when both registers are full and output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without cause");

    // A finished field must have had bytes: field_done without a byte needs prior bytes
    a_done_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_out.field_done && !n_out.byte_valid) |->
            r_state.field_has_bytes)
        else $error("field end without field bytes");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import qfs_pkg::*;

    typedef logic [7:0] t_byte_list[$];

    // Reference scan state and expected result words for the splitter
    class field_scoreboard;
        t_state  scan;
        t_result expected_q[$];
        int      mismatches;
        int      results_checked;
        int      fields_closed;

        function new();
            scan = '0;
            mismatches = 0;
            results_checked = 0;
            fields_closed = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void log_fault(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        // Advance the scan state by one accepted input word
        function void note_word(logic [7:0] c, logic last);
            t_result    r;
            logic       emit;
            logic       done;
            logic [7:0] closer;
            emit = 1'b0;
            done = 1'b0;
            if (scan.quote_mode != QM_SINGLE && scan.quote_mode != QM_DOUBLE) begin
                // outside quotes; an unknown mode code counts as outside
                scan.quote_mode = QM_OUTSIDE;
                if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_SPACE) begin
                    done = scan.field_has_bytes;
                    scan.field_has_bytes = 1'b0;
                    if (c == CH_SQUOTE) begin
                        scan.quote_mode = QM_SINGLE;
                    end else if (c == CH_DQUOTE) begin
                        scan.quote_mode = QM_DOUBLE;
                    end
                end else begin
                    emit = 1'b1;
                end
            end else begin
                closer = (scan.quote_mode == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (scan.escape_pending) begin
                    scan.escape_pending = 1'b0;
                    emit = 1'b1;
                end else if (c == closer) begin
                    scan.quote_mode = QM_OUTSIDE;
                    done = scan.field_has_bytes;
                    scan.field_has_bytes = 1'b0;
                end else if (c == CH_BSLASH) begin
                    scan.escape_pending = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                scan.field_has_bytes = 1'b1;
            end
            // line end flushes any open field and clears everything
            if (last) begin
                if (scan.field_has_bytes) begin
                    done = 1'b1;
                end
                scan = '0;
            end
            r.field_byte = emit ? c : 8'h00;
            r.byte_valid = emit;
            r.field_done = done;
            r.line_done  = last;
            expected_q = {expected_q, r};
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_word(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                log_fault($sformatf("unexpected result byte=%h valid=%b done=%b line=%b",
                    got.field_byte, got.byte_valid, got.field_done, got.line_done));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (want.field_done) begin
                fields_closed++;
            end
            if (got.field_byte !== want.field_byte || got.byte_valid !== want.byte_valid ||
                got.field_done !== want.field_done || got.line_done !== want.line_done) begin
                log_fault($sformatf({"result %0d: expected byte=%h valid=%b done=%b line=%b,",
                    " got byte=%h valid=%b done=%b line=%b"}, results_checked,
                    want.field_byte, want.byte_valid, want.field_done, want.line_done,
                    got.field_byte, got.byte_valid, got.field_done, got.line_done));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_char_byte = 8'h00;
    logic       i_line_last = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_field_byte;
    logic       o_byte_valid;
    logic       o_field_done;
    logic       o_line_done;

    field_scoreboard sb = new();
    int words_sent = 0;
    int lines_sent = 0;
    int clean_lines = 0;
    int noisy_lines = 0;
    int pauses = 0;
    bit rx_quiet = 1'b0;

    quoted_field_splitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_byte  (i_char_byte),
        .i_line_last  (i_line_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_field_byte (o_field_byte),
        .o_byte_valid (o_byte_valid),
        .o_field_done (o_field_done),
        .o_line_done  (o_line_done)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: stall for a random count before each word, quiet stretches too
    initial begin
        int wait_cycles;
        int taken;
        taken = 0;
        forever begin
            if (taken % 40 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            wait_cycles = rx_quiet ? 0 : $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
            taken++;
        end
    end

    // Check every result word taken at an edge
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got.field_byte = o_field_byte;
            got.byte_valid = o_byte_valid;
            got.field_done = o_field_done;
            got.line_done  = o_line_done;
            sb.check_word(got);
        end
    end

    // Offer one input word after a random gap and wait until it is taken
    task automatic send_word(input logic [7:0] c, input logic last, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_byte <= c;
        i_line_last <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_word(c, last);
        words_sent++;
    endtask

    task automatic send_line(input t_byte_list line);
        bit no_gap;
        no_gap = ($urandom_range(0, 3) == 0);
        foreach (line[k]) begin
            send_word(line[k], k == line.size() - 1, no_gap);
        end
        lines_sent++;
    endtask

    // Hold the input side until every outstanding result has been taken
    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        pauses++;
    endtask

    // Printable byte that is not a quote or backslash
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126));
        while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // Words and quoted fields, with escapes; sometimes left broken
    function automatic t_byte_list clean_line();
        t_byte_list line;
        int         ntok;
        int         nlen;
        logic [7:0] q;
        ntok = $urandom_range(1, 4);
        for (int t = 0; t < ntok; t++) begin
            repeat ($urandom_range(0, 2)) line = {line, CH_SPACE};
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 5)) line = {line, plain_char()};
            end else begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                line = {line, q};
                nlen = $urandom_range(0, 5);
                for (int k = 0; k < nlen; k++) begin
                    case ($urandom_range(0, 7))
                        0, 1: begin
                            line = {line, CH_BSLASH};
                            line = {line, 8'($urandom_range(0, 255))};
                        end
                        2: line = {line, (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE};
                        3: line = {line, CH_SPACE};
                        default: line = {line, plain_char()};
                    endcase
                end
                if ($urandom_range(0, 7) == 0) begin
                    // unterminated, possibly with a dangling escape
                    if ($urandom_range(0, 1)) line = {line, CH_BSLASH};
                    break;
                end
                line = {line, q};
            end
        end
        return line;
    endfunction

    // Random bytes, heavy on the steering codes
    function automatic t_byte_list noisy_line();
        t_byte_list line;
        int         n;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: line = {line, CH_SQUOTE};
                1: line = {line, CH_DQUOTE};
                2: line = {line, CH_SPACE};
                3: line = {line, CH_BSLASH};
                default: line = {line, 8'($urandom_range(0, 255))};
            endcase
        end
        return line;
    endfunction

    initial begin
        t_byte_list line;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, ordinary backslash outside quotes, other quote
        // inside quotes, escaped quote, escaped backslash, escaped plain byte,
        // double-quoted field, repeated spaces
        line = '{8'h00, 8'hFF, CH_SPACE, CH_BSLASH, CH_SQUOTE, 8'h61, CH_DQUOTE,
                 CH_BSLASH, CH_SQUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h7A,
                 CH_SQUOTE, CH_DQUOTE, 8'h62, CH_DQUOTE, CH_SPACE, CH_SPACE, 8'h63};
        send_line(line);
        // quote as the final byte of a line
        line = '{CH_DQUOTE};
        send_line(line);
        // unterminated quote with a dangling escape at line end
        line = '{CH_SQUOTE, 8'h71, CH_BSLASH};
        send_line(line);
        drain_pause();

        // Random lines, mostly well formed
        while (words_sent < 650) begin
            if ($urandom_range(0, 9) < 7) begin
                line = clean_line();
                clean_lines++;
            end else begin
                line = noisy_line();
                noisy_lines++;
            end
            send_line(line);
            if (lines_sent % 40 == 0) begin
                drain_pause();
            end
        end
        i_valid <= 1'b0;

        // Let the remaining results come out, then idle before the summary
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words in %0d lines (%0d well formed, %0d noisy), %0d drain pauses.",
            words_sent, lines_sent, clean_lines, noisy_lines, pauses);
        $display("Checked %0d result words, %0d of them closing a field; %0d mismatches.",
            sb.results_checked, sb.fields_closed, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
